// ===== hdl/nmwe_pkg.sv =====
// ----------------------------------------------------------------------------
// nmwe_pkg
// Shared types, constants and the integer sizing function of the
// null-aware minimal-width key encoder.
// ----------------------------------------------------------------------------
package nmwe_pkg;

  // Value byte counts and bit widths
  localparam logic [4:0] BYTE_1  = 5'd1;
  localparam logic [4:0] BYTE_2  = 5'd2;
  localparam logic [4:0] BYTE_4  = 5'd4;
  localparam logic [4:0] BYTE_8  = 5'd8;
  localparam logic [4:0] BYTE_16 = 5'd16;
  localparam int BIT_8  = 8;
  localparam int BIT_32 = 32;
  localparam int BIT_64 = 64;

  typedef enum logic [1:0] {
    KIND_INT    = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_BOOL   = 2'd2,
    KIND_DEC128 = 2'd3
  } kind_t;

  // Classified request: value byte count (0 for null) and 128-bit payload
  typedef struct packed {
    logic [4:0]          size;
    logic [2*BIT_64-1:0] data;
  } desc_t;

  // Smallest of 1, 2, 4 or 8 bytes that holds v as signed two's complement
  function automatic logic [4:0] int_size(input logic [BIT_64-1:0] v);
    logic [BIT_64-1:0] m;
    logic [4:0]        s;
    m = v[BIT_64-1] ? ~v : v;
    if (m[BIT_64-1:7] == '0) begin
      s = BYTE_1;
    end else if (m[BIT_64-1:15] == '0) begin
      s = BYTE_2;
    end else if (m[BIT_64-1:BIT_32-1] == '0) begin
      s = BYTE_4;
    end else begin
      s = BYTE_8;
    end
    return s;
  endfunction

endpackage

// ===== hdl/nmwe_front.sv =====
// ----------------------------------------------------------------------------
// nmwe_front
// Accepts one column value per request, sizes it and registers the
// resulting descriptor for the queue.
// ----------------------------------------------------------------------------
module nmwe_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_kind,
  input  logic                    in_null,
  input  logic [63:0]             in_lo,
  input  logic [63:0]             in_hi,
  output logic                    desc_valid,
  input  logic                    desc_ready,
  output nmwe_pkg::desc_t         desc
);
  import nmwe_pkg::*;

  desc_t desc_next;

  // Classify the incoming value
  always_comb begin
    desc_next.data = {in_hi, in_lo};
    unique case (kind_t'(in_kind))
      KIND_INT: begin
        desc_next.size = int_size(in_lo);
      end
      KIND_DOUBLE: begin
        desc_next.size = BYTE_8;
      end
      KIND_BOOL: begin
        desc_next.size = BYTE_1;
        desc_next.data = {{(2*BIT_64-1){1'b0}}, |in_lo};
      end
      KIND_DEC128: begin
        desc_next.size = BYTE_16;
      end
      default: begin
        desc_next.size = BYTE_8;
      end
    endcase
    if (in_null) begin
      desc_next.size = '0;
    end
  end

  assign in_ready = !desc_valid || desc_ready;

  // Hold the descriptor until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (in_ready) begin
      desc_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      desc <= desc_next;
    end
  end

endmodule

// ===== hdl/nmwe_queue.sv =====
// ----------------------------------------------------------------------------
// nmwe_queue
// Two-entry descriptor queue between the front and the byte serializer.
// ----------------------------------------------------------------------------
module nmwe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  nmwe_pkg::desc_t wr_desc,
  output logic            rd_valid,
  input  logic            rd_ready,
  output nmwe_pkg::desc_t rd_desc
);
  import nmwe_pkg::*;

  desc_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_desc  = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_desc;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// ===== hdl/nmwe_back.sv =====
// ----------------------------------------------------------------------------
// nmwe_back
// Serializes one descriptor into its size byte and value bytes, least
// significant first, through a registered byte output.
// ----------------------------------------------------------------------------
module nmwe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  nmwe_pkg::desc_t q_desc,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import nmwe_pkg::*;

  desc_t      cur;
  logic       cur_valid;
  logic [4:0] pos;
  logic [4:0] pos_next;
  logic [3:0] idx;
  logic       load;
  logic       byte_last;
  logic       take;
  logic [7:0] byte_next;

  assign load      = !out_valid || out_ready;
  assign byte_last = (pos == cur.size);
  assign take      = load && cur_valid && byte_last;
  assign q_ready   = !cur_valid || take;
  assign idx       = 4'(pos - 5'd1);
  assign pos_next  = pos + 5'd1;

  // Pick the size byte first, then value bytes
  always_comb begin
    if (pos == 5'd0) begin
      byte_next = {3'b000, cur.size};
    end else begin
      byte_next = cur.data[{idx, 3'b000} +: BIT_8];
    end
  end

  // Track the current descriptor and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
    end else if (q_ready) begin
      cur_valid <= q_valid;
      pos       <= '0;
    end else if (load && cur_valid) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      cur <= q_desc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && cur_valid) begin
      out_byte <= byte_next;
      out_last <= byte_last;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (pos <= cur.size))
    else $error("byte position past end of value");

  a_size_legal: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.size == 5'd0 || cur.size == BYTE_1 || cur.size == BYTE_2 ||
                   cur.size == BYTE_4 || cur.size == BYTE_8 || cur.size == BYTE_16))
    else $error("illegal value size");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// ===== hdl/null_aware_min_width_int_encoder.sv =====
// Path: front register, queue entry, serializer register, output byte register.
// Throughput: one key byte per cycle unless m_axis_tready is low; a value's key
//   has 1 + size bytes (1 for null, 2/3/5/9 for integers, 9 double, 2 boolean,
//   17 decimal); the byte serializer sets the rate, values follow with no gap.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
// ----------------------------------------------------------------------------
// null_aware_min_width_int_encoder
// Encodes column values as length-prefixed minimal-width little-endian keys.
// ----------------------------------------------------------------------------
module null_aware_min_width_int_encoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // value_lo[63:0], value_hi[127:64]
  input  logic [2:0]   s_axis_tuser,  // kind[1:0], is_null[2]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // out_byte[7:0]
  output logic         m_axis_tlast
);
  import nmwe_pkg::*;

  logic  f_valid;
  logic  f_ready;
  desc_t f_desc;
  logic  q_valid;
  logic  q_ready;
  desc_t q_desc;

  // Accept and classify
  nmwe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_kind    (s_axis_tuser[1:0]),
    .in_null    (s_axis_tuser[2]),
    .in_lo      (s_axis_tdata[63:0]),
    .in_hi      (s_axis_tdata[127:64]),
    .desc_valid (f_valid),
    .desc_ready (f_ready),
    .desc       (f_desc)
  );

  // Decouple front and back
  nmwe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_desc  (f_desc),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_desc  (q_desc)
  );

  // Serialize bytes
  nmwe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_desc    (q_desc),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== tb/null_aware_min_width_int_encoder_test.sv =====
// ----------------------------------------------------------------------------
// null_aware_min_width_int_encoder_test
// Drives column values into the key encoder and checks every emitted key
// byte and its tlast flag against a local encoding of the same value.
// Covers nulls, every kind, the integer size boundaries and random values,
// with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module null_aware_min_width_int_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nmwe_pkg::*;

  // One expected key byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } key_byte_t;

  // Holds the key bytes owed by accepted values and checks the output stream
  class key_checker;
    key_byte_t key_bytes_due[$];
    int        errors = 0;
    int        bytes_checked = 0;

    // Encode an accepted value into the bytes the block must emit
    function void encode_value(kind_t kind, logic is_null, logic [63:0] lo,
                               logic [63:0] hi);
      logic [63:0]  mag;
      logic [127:0] payload;
      int           nbytes;
      if (is_null) begin
        key_bytes_due.push_back('{data: 8'h00, last: 1'b1});
        return;
      end
      payload = {hi, lo};
      case (kind)
        KIND_DOUBLE: begin
          nbytes = BYTE_8;
        end
        KIND_BOOL: begin
          nbytes = BYTE_1;
          payload = (lo != 64'd0) ? 128'd1 : 128'd0;
        end
        KIND_DEC128: begin
          nbytes = BYTE_16;
        end
        default: begin
          // size negatives on their complement
          mag = lo[63] ? ~lo : lo;
          if (mag < 64'h80) nbytes = BYTE_1;
          else if (mag < 64'h8000) nbytes = BYTE_2;
          else if (mag < 64'h8000_0000) nbytes = BYTE_4;
          else nbytes = BYTE_8;
        end
      endcase
      key_bytes_due.push_back('{data: nbytes[7:0], last: 1'b0});
      for (int i = 0; i < nbytes; i++) begin
        key_bytes_due.push_back('{data: payload[8*i +: 8], last: (i == nbytes - 1)});
      end
    endfunction

    // Compare one emitted byte with the oldest owed byte
    function void match_byte(logic [7:0] data, logic last);
      key_byte_t due;
      bytes_checked++;
      if (key_bytes_due.size() == 0) begin
        $display("%0t: unexpected key byte, expected none, actual data %02h last %0b",
                 $time, data, last);
        errors++;
        return;
      end
      due = key_bytes_due.pop_front();
      if (data !== due.data) begin
        $display("%0t: key byte mismatch, expected %02h, actual %02h",
                 $time, due.data, data);
        errors++;
      end
      if (last !== due.last) begin
        $display("%0t: tlast mismatch, expected %0b, actual %0b",
                 $time, due.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return key_bytes_due.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // value_lo[63:0], value_hi[127:64]
  logic [2:0]   s_axis_tuser = '0;   // kind[1:0], is_null[2]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;        // out_byte[7:0]
  logic         m_axis_tlast;

  key_checker board = new();
  logic       steady = 1'b0;
  int         values_sent = 0;
  int         nulls_sent = 0;
  int         kind_count [4] = '{0, 0, 0, 0};

  null_aware_min_width_int_encoder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Check accepted key bytes, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.match_byte(m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 37);
  end

  // Offer one value and hold it until accepted
  task automatic send_value(kind_t kind, logic is_null, logic [63:0] lo,
                            logic [63:0] hi);
    while (!steady && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    s_axis_tuser  <= {is_null, kind};
    do @(posedge clk); while (!s_axis_tready);
    board.encode_value(kind, is_null, lo, hi);
    values_sent++;
    if (is_null) nulls_sent++;
    else kind_count[kind]++;
  endtask

  // Hold off the sender until every owed byte has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Random integer of a random significant width, sign-extended to 64 bits
  function automatic logic [63:0] rand_int();
    logic [63:0] v;
    logic [63:0] mask;
    int          w;
    v = rand_word();
    w = $urandom_range(64, 1);
    mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    return v[w-1] ? (v | ~mask) : (v & mask);
  endfunction

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    kind_t       kind;
    logic        is_null;
    logic [63:0] lo;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: nulls of every kind with value bits set
    send_value(KIND_INT,    1'b1, '1, '1);
    send_value(KIND_DOUBLE, 1'b1, '1, '0);
    send_value(KIND_BOOL,   1'b1, 64'd1, '1);
    send_value(KIND_DEC128, 1'b1, '1, '1);
    // Directed: integer size boundaries, small values and extremes
    send_value(KIND_INT, 1'b0, 64'd0, '1);
    send_value(KIND_INT, 1'b0, '1, '1);
    send_value(KIND_INT, 1'b0, 64'd127, '0);
    send_value(KIND_INT, 1'b0, 64'd128, '0);
    send_value(KIND_INT, 1'b0, -64'sd128, '0);
    send_value(KIND_INT, 1'b0, -64'sd129, '0);
    send_value(KIND_INT, 1'b0, 64'd32767, '0);
    send_value(KIND_INT, 1'b0, 64'd32768, '0);
    send_value(KIND_INT, 1'b0, -64'sd32769, '0);
    send_value(KIND_INT, 1'b0, 64'h7FFF_FFFF, '0);
    send_value(KIND_INT, 1'b0, 64'h8000_0000, '0);
    send_value(KIND_INT, 1'b0, 64'hFFFF_FFFF_7FFF_FFFF, '0);
    send_value(KIND_INT, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    send_value(KIND_INT, 1'b0, 64'h8000_0000_0000_0000, '0);
    // Directed: double, booleans including a non-canonical one, decimals
    send_value(KIND_DOUBLE, 1'b0, 64'h3FF0_0000_0000_0000, '1);
    send_value(KIND_BOOL,   1'b0, 64'd0, '1);
    send_value(KIND_BOOL,   1'b0, 64'd1, '0);
    send_value(KIND_BOOL,   1'b0, 64'h8000_0000_0000_0005, '0);
    send_value(KIND_DEC128, 1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    send_value(KIND_DEC128, 1'b0, '1, '1);
    drain();

    // Random values: every kind chosen evenly, integers of varied widths
    for (int n = 0; n < 80; n++) begin
      steady = (n >= 30 && n < 60);
      if (n == 70) drain();
      kind = kind_t'($urandom_range(3));
      is_null = ($urandom_range(99) < 15);
      case (kind)
        KIND_INT:  lo = rand_int();
        KIND_BOOL: lo = ($urandom_range(2) == 0) ? rand_word() : 64'($urandom_range(1));
        default:   lo = rand_word();
      endcase
      send_value(kind, is_null, lo, rand_word());
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d values (%0d null; int %0d, double %0d, bool %0d, decimal %0d)",
             values_sent, nulls_sent, kind_count[KIND_INT], kind_count[KIND_DOUBLE],
             kind_count[KIND_BOOL], kind_count[KIND_DEC128]);
    $display("Checked %0d key bytes under random stalls on both sides",
             board.bytes_checked);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
